// ===== rtl/grey_wolf_optimizer_step_top_macros.svh =====
// Assertion macros shared by the checker file of the grey wolf step engine.
`ifndef GREY_WOLF_OPTIMIZER_STEP_TOP_MACROS_SVH
`define GREY_WOLF_OPTIMIZER_STEP_TOP_MACROS_SVH

// Same-cycle implication, off while reset is high.
`define GWO_ASSERT_IMP(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("gwo check failed");

// Next-cycle implication, active during reset as well.
`define GWO_ASSERT_NXT(label, clk, pre, post) \
   label: assert property (@(posedge clk) (pre) |=> (post)) \
      else $error("gwo check failed");

`endif

// ===== rtl/gwo_pkg.sv =====
// Types and constants shared by the grey wolf step engine modules.
package gwo_pkg;

   // Action codes of a request
   localparam logic [2:0] ACT_LOAD  = 3'd0;
   localparam logic [2:0] ACT_READ  = 3'd1;
   localparam logic [2:0] ACT_FIT   = 3'd2;
   localparam logic [2:0] ACT_UPD   = 3'd3;
   localparam logic [2:0] ACT_LREAD = 3'd4;

   // Configuration register indexes
   localparam logic [2:0] REG_LOWER = 3'd0;
   localparam logic [2:0] REG_UPPER = 3'd1;
   localparam logic [2:0] REG_AGENTS = 3'd2;
   localparam logic [2:0] REG_DIMS  = 3'd3;

   // Leader change codes
   localparam logic [1:0] CHG_NONE  = 2'd0;

   localparam logic signed [31:0] SCORE_INF = 32'sh7FFF_FFFF;

   // Fixed point and divider constants
   localparam int ACC_W      = 64;
   localparam int DIV_W      = 48;
   localparam int DIV_DIGITS = 4;
   localparam int DIV_STEPS  = DIV_W / DIV_DIGITS;
   localparam logic [ACC_W-1:0] ROUND_DIV = 64'd98304;

   typedef enum logic [2:0] {
      K_LOAD, K_READ, K_FIT, K_UPD, K_LREAD, K_ERR, K_NOP
   } kind_type;

   typedef enum logic [3:0] {
      B_IDLE, B_EXEC, B_AGENT_DATA, B_LEAD_DATA, B_COPY, B_UPD_L1, B_UPD_L2,
      B_UPD_L3, B_TERM, B_ROUND, B_DIV, B_CLAMP, B_RESULT
   } bstate_type;

   typedef struct packed {
      logic signed [31:0] lower_bound;
      logic signed [31:0] upper_bound;
      logic [5:0]         agent_count;
      logic [6:0]         dimension_count;
   } cfg_type;

   typedef struct packed {
      kind_type           kind;
      logic [4:0]         agent;
      logic [5:0]         dim;
      logic signed [31:0] value;
      logic [17:0]        a_coeff;
      logic [2:0][15:0]   rand_a;
      logic [2:0][15:0]   rand_c;
   } cmd_type;

   typedef struct packed {
      logic signed [31:0] position;
      logic signed [31:0] score;
      logic [1:0]         changed;
      logic               index_error;
   } rsp_type;

endpackage

// ===== rtl/grey_wolf_optimizer_step_top.sv =====
// Top level of the grey wolf optimizer step engine.
//
//   channel   direction  handshake            payload
//   req_      in         push / full          action agent dim value a_coeff rand_*
//   rsp_      out        empty / pop          position_out score_out leader_changed
//                                             index_error
//   csr_      in         write, no wait       index, wdata
//
// A pushed request is registered into the front queue; the back end runs one
// command at a time. Load and error go straight to the result, reads wait on
// a memory read first, a fitness report that changes a leader copies the agent's
// D elements (one per cycle, D = dimensions in use); an element update runs three
// leader terms on a shared datapath, then a divide by three at four bits a cycle.
// Reset is synchronous; leader elements carry valid bits, so no clearing pass.
// Each side stalls on its own through the two-entry command and result queues.
module grey_wolf_optimizer_step_top #(
   parameter int MAX_AGENTS = 32,
   parameter int MAX_DIMS   = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_push,
   output logic               req_full,
   input  logic [2:0]         req_action,
   input  logic [4:0]         req_agent,
   input  logic [5:0]         req_dim,
   input  logic signed [31:0] req_value,
   input  logic [17:0]        req_a_coeff,
   input  logic [15:0]        req_rand_a1,
   input  logic [15:0]        req_rand_c1,
   input  logic [15:0]        req_rand_a2,
   input  logic [15:0]        req_rand_c2,
   input  logic [15:0]        req_rand_a3,
   input  logic [15:0]        req_rand_c3,
   output logic               rsp_empty,
   input  logic               rsp_pop,
   output logic signed [31:0] rsp_position_out,
   output logic signed [31:0] rsp_score_out,
   output logic [1:0]         rsp_leader_changed,
   output logic               rsp_index_error,
   input  logic               csr_write,
   input  logic [2:0]         csr_index,
   input  logic [31:0]        csr_wdata
);

   gwo_pkg::cfg_type cfg_ff, cfg_in;
   gwo_pkg::cmd_type cmd;
   gwo_pkg::rsp_type rsp;
   logic             cmd_valid, cmd_pop;

   // Decode configuration writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_index)
            gwo_pkg::REG_LOWER:  cfg_in.lower_bound = csr_wdata;
            gwo_pkg::REG_UPPER:  cfg_in.upper_bound = csr_wdata;
            gwo_pkg::REG_AGENTS: cfg_in.agent_count = csr_wdata[5:0];
            gwo_pkg::REG_DIMS:   cfg_in.dimension_count = csr_wdata[6:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.lower_bound <= 32'sh8000_0000;
         cfg_ff.upper_bound <= 32'sh7FFF_FFFF;
         cfg_ff.agent_count <= 6'd32;
         cfg_ff.dimension_count <= 7'd64;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   gwo_front #(.MAX_AGENTS(MAX_AGENTS), .MAX_DIMS(MAX_DIMS)) u_front (
      .clock(clock), .reset(reset), .cfg(cfg_ff),
      .req_push(req_push), .req_full(req_full),
      .req_action(req_action), .req_agent(req_agent), .req_dim(req_dim),
      .req_value(req_value), .req_a_coeff(req_a_coeff),
      .req_rand_a1(req_rand_a1), .req_rand_c1(req_rand_c1),
      .req_rand_a2(req_rand_a2), .req_rand_c2(req_rand_c2),
      .req_rand_a3(req_rand_a3), .req_rand_c3(req_rand_c3),
      .cmd_valid(cmd_valid), .cmd_pop(cmd_pop), .cmd(cmd)
   );

   gwo_back #(.MAX_AGENTS(MAX_AGENTS), .MAX_DIMS(MAX_DIMS)) u_back (
      .clock(clock), .reset(reset), .cfg(cfg_ff),
      .cmd_valid(cmd_valid), .cmd_pop(cmd_pop), .cmd(cmd),
      .rsp_empty(rsp_empty), .rsp_pop(rsp_pop), .rsp(rsp)
   );

   assign rsp_position_out = rsp.position;
   assign rsp_score_out = rsp.score;
   assign rsp_leader_changed = rsp.changed;
   assign rsp_index_error = rsp.index_error;

endmodule

// ===== rtl/gwo_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module gwo_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 2048
) (
   input  logic                                   clock,
   input  logic                                   we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                       wdata,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                       rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/gwo_front.sv =====
// Front end: accepts requests, checks indexes and queues decoded commands.
module gwo_front #(
   parameter int MAX_AGENTS = 32,
   parameter int MAX_DIMS   = 64
) (
   input  logic                 clock,
   input  logic                 reset,
   input  gwo_pkg::cfg_type     cfg,
   input  logic                 req_push,
   output logic                 req_full,
   input  logic [2:0]           req_action,
   input  logic [4:0]           req_agent,
   input  logic [5:0]           req_dim,
   input  logic signed [31:0]   req_value,
   input  logic [17:0]          req_a_coeff,
   input  logic [15:0]          req_rand_a1,
   input  logic [15:0]          req_rand_c1,
   input  logic [15:0]          req_rand_a2,
   input  logic [15:0]          req_rand_c2,
   input  logic [15:0]          req_rand_a3,
   input  logic [15:0]          req_rand_c3,
   output logic                 cmd_valid,
   input  logic                 cmd_pop,
   output gwo_pkg::cmd_type     cmd
);

   gwo_pkg::cmd_type q_ff [2];
   gwo_pkg::cmd_type q_in [2];
   logic       wr_ff, wr_in, rd_ff, rd_in;
   logic [1:0] cnt_ff, cnt_in;
   gwo_pkg::cmd_type dec;
   logic [8:0] na, nd;
   logic       agent_bad, dim_bad, push, pop;

   // Classify the request against the counts in use
   always_comb begin
      na = (9'(cfg.agent_count) > 9'(MAX_AGENTS)) ? 9'(MAX_AGENTS) : 9'(cfg.agent_count);
      nd = (9'(cfg.dimension_count) > 9'(MAX_DIMS)) ? 9'(MAX_DIMS)
                                                    : 9'(cfg.dimension_count);
      agent_bad = 9'(req_agent) >= na;
      dim_bad = 9'(req_dim) >= nd;
      dec.agent = req_agent;
      dec.dim = req_dim;
      dec.value = req_value;
      dec.a_coeff = req_a_coeff;
      dec.rand_a = {req_rand_a3, req_rand_a2, req_rand_a1};
      dec.rand_c = {req_rand_c3, req_rand_c2, req_rand_c1};
      unique case (req_action)
         gwo_pkg::ACT_LOAD: begin
            dec.kind = (agent_bad || dim_bad) ? gwo_pkg::K_ERR : gwo_pkg::K_LOAD;
         end
         gwo_pkg::ACT_READ: begin
            dec.kind = (agent_bad || dim_bad) ? gwo_pkg::K_ERR : gwo_pkg::K_READ;
         end
         gwo_pkg::ACT_FIT: begin
            dec.kind = agent_bad ? gwo_pkg::K_ERR : gwo_pkg::K_FIT;
         end
         gwo_pkg::ACT_UPD: begin
            dec.kind = (agent_bad || dim_bad) ? gwo_pkg::K_ERR : gwo_pkg::K_UPD;
         end
         gwo_pkg::ACT_LREAD: begin
            dec.kind = (req_agent > 5'd2 || dim_bad) ? gwo_pkg::K_ERR : gwo_pkg::K_LREAD;
         end
         default: begin
            dec.kind = gwo_pkg::K_NOP;
         end
      endcase
   end

   // Two-entry command queue
   assign req_full = cnt_ff == 2'd2;
   assign cmd_valid = cnt_ff != 2'd0;
   assign cmd = q_ff[rd_ff];
   assign push = req_push && !req_full;
   assign pop = cmd_pop && cmd_valid;

   always_comb begin
      q_in = q_ff;
      wr_in = wr_ff;
      rd_in = rd_ff;
      cnt_in = cnt_ff;
      if (push) begin
         q_in[wr_ff] = dec;
         wr_in = ~wr_ff;
      end
      if (pop) begin
         rd_in = ~rd_ff;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 2'd1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= 1'b0;
         rd_ff <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ff <= wr_in;
         rd_ff <= rd_in;
         cnt_ff <= cnt_in;
      end
      q_ff <= q_in;
   end

endmodule

// ===== rtl/gwo_back.sv =====
// Back end: executes commands against position memories and leader state.
module gwo_back #(
   parameter int MAX_AGENTS = 32,
   parameter int MAX_DIMS   = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  gwo_pkg::cfg_type cfg,
   input  logic             cmd_valid,
   output logic             cmd_pop,
   input  gwo_pkg::cmd_type cmd,
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output gwo_pkg::rsp_type rsp
);

   localparam int ADEPTH = MAX_AGENTS * MAX_DIMS;
   localparam int AW  = (ADEPTH > 1) ? $clog2(ADEPTH) : 1;
   localparam int LDEPTH = 3 * MAX_DIMS;
   localparam int LAW = $clog2(LDEPTH);
   localparam int CW  = $clog2(MAX_DIMS + 1);
   localparam int DW  = gwo_pkg::DIV_W;
   localparam int DD  = gwo_pkg::DIV_DIGITS;

   // Agent and leader memory ports
   logic          aw_en, lw_en;
   logic [AW-1:0] aw_addr, ar_addr;
   logic [LAW-1:0] lw_addr, lr_addr;
   logic [31:0]   aw_data, ar_data, lw_data, lr_data;

   gwo_ram #(.WIDTH(32), .DEPTH(ADEPTH)) u_agent_ram (
      .clock(clock), .we(aw_en), .waddr(aw_addr), .wdata(aw_data),
      .raddr(ar_addr), .rdata(ar_data)
   );

   gwo_ram #(.WIDTH(32), .DEPTH(LDEPTH)) u_leader_ram (
      .clock(clock), .we(lw_en), .waddr(lw_addr), .wdata(lw_data),
      .raddr(lr_addr), .rdata(lr_data)
   );

   gwo_pkg::bstate_type state_ff, state_in;
   gwo_pkg::cmd_type    cur_ff, cur_in;
   logic signed [31:0]  x_ff, x_in;
   logic signed [31:0]  lead_ff [3];
   logic signed [31:0]  lead_in [3];
   logic [1:0]          k_ff, k_in, slot_ff, slot_in;
   logic [2:0]          ph_ff, ph_in;
   logic [34:0]         pa_ff, pa_in;
   logic signed [20:0]  a16_ff, a16_in;
   logic signed [50:0]  diff_ff, diff_in;
   logic [35:0]         d16_ff, d16_in;
   logic signed [57:0]  prod_ff, prod_in;
   logic signed [gwo_pkg::ACC_W-1:0] acc_ff, acc_in;
   logic                neg_ff, neg_in;
   logic [DW-1:0]       n_ff, n_in, q_ff, q_in;
   logic [1:0]          r_ff, r_in;
   logic [3:0]          step_ff, step_in;
   logic [CW-1:0]       cnt_ff, cnt_in;
   logic signed [31:0]  res_pos_ff, res_pos_in, res_score_ff, res_score_in;
   logic [1:0]          res_chg_ff, res_chg_in;
   logic                res_err_ff, res_err_in;
   logic signed [31:0]  alpha_ff, alpha_in, beta_ff, beta_in, delta_ff, delta_in;
   logic [LDEPTH-1:0]   lvalid_ff, lvalid_in;
   logic                lrv_ff, lrv_in;

   // Result queue
   gwo_pkg::rsp_type    out_ff [2];
   gwo_pkg::rsp_type    out_in [2];
   logic                owr_ff, owr_in, ord_ff, ord_in;
   logic [1:0]          ocnt_ff, ocnt_in;
   logic                out_push, out_full;
   gwo_pkg::rsp_type    out_item;

   logic [8:0] nd;

   assign nd = (9'(cfg.dimension_count) > 9'(MAX_DIMS)) ? 9'(MAX_DIMS)
                                                        : 9'(cfg.dimension_count);

   function automatic logic [AW-1:0] agent_addr(input logic [4:0] ag, input logic [31:0] d);
      logic [31:0] t;
      t = 32'(ag) * 32'(MAX_DIMS) + d;
      return t[AW-1:0];
   endfunction

   function automatic logic [LAW-1:0] leader_addr(input logic [1:0] sl, input logic [31:0] d);
      logic [31:0] t;
      t = 32'(sl) * 32'(MAX_DIMS) + d;
      return t[LAW-1:0];
   endfunction

   // Sequencer: next state, datapath and memory controls
   always_comb begin
      logic [15:0]         r1, r2;
      logic signed [31:0]  ld;
      logic [50:0]         mag51;
      logic [51:0]         t52;
      logic [34:0]         pr;
      logic [gwo_pkg::ACC_W-1:0] mag64;
      logic [1:0]          rem;
      logic [2:0]          r3;
      logic [DD-1:0]       qd;
      logic signed [DW:0]  qs, v;
      logic                hit;

      state_in = state_ff;
      cur_in = cur_ff;
      x_in = x_ff;
      lead_in = lead_ff;
      k_in = k_ff;
      slot_in = slot_ff;
      ph_in = ph_ff;
      pa_in = pa_ff;
      a16_in = a16_ff;
      diff_in = diff_ff;
      d16_in = d16_ff;
      prod_in = prod_ff;
      acc_in = acc_ff;
      neg_in = neg_ff;
      n_in = n_ff;
      q_in = q_ff;
      r_in = r_ff;
      step_in = step_ff;
      cnt_in = cnt_ff;
      res_pos_in = res_pos_ff;
      res_score_in = res_score_ff;
      res_chg_in = res_chg_ff;
      res_err_in = res_err_ff;
      alpha_in = alpha_ff;
      beta_in = beta_ff;
      delta_in = delta_ff;
      lvalid_in = lvalid_ff;
      lrv_in = lrv_ff;
      cmd_pop = 1'b0;
      out_push = 1'b0;
      aw_en = 1'b0;
      aw_addr = '0;
      aw_data = '0;
      ar_addr = '0;
      lw_en = 1'b0;
      lw_addr = '0;
      lw_data = '0;
      lr_addr = '0;
      r1 = cur_ff.rand_a[k_ff];
      r2 = cur_ff.rand_c[k_ff];
      ld = lead_ff[k_ff];
      mag51 = '0;
      t52 = '0;
      pr = '0;
      mag64 = '0;
      rem = r_ff;
      r3 = '0;
      qd = '0;
      qs = '0;
      v = '0;
      hit = 1'b0;

      unique case (state_ff)
         gwo_pkg::B_IDLE: begin
            if (cmd_valid) begin
               cmd_pop = 1'b1;
               cur_in = cmd;
               state_in = gwo_pkg::B_EXEC;
            end
         end
         gwo_pkg::B_EXEC: begin
            res_pos_in = '0;
            res_chg_in = gwo_pkg::CHG_NONE;
            res_err_in = 1'b0;
            state_in = gwo_pkg::B_RESULT;
            unique case (cur_ff.kind)
               gwo_pkg::K_LOAD: begin
                  aw_en = 1'b1;
                  aw_addr = agent_addr(cur_ff.agent, 32'(cur_ff.dim));
                  aw_data = cur_ff.value;
               end
               gwo_pkg::K_READ: begin
                  ar_addr = agent_addr(cur_ff.agent, 32'(cur_ff.dim));
                  state_in = gwo_pkg::B_AGENT_DATA;
               end
               gwo_pkg::K_LREAD: begin
                  lr_addr = leader_addr(cur_ff.agent[1:0], 32'(cur_ff.dim));
                  lrv_in = lvalid_ff[lr_addr];
                  state_in = gwo_pkg::B_LEAD_DATA;
               end
               gwo_pkg::K_FIT: begin
                  // Strict tests: alpha, then beta, then delta
                  if (cur_ff.value < alpha_ff) begin
                     alpha_in = cur_ff.value;
                     slot_in = 2'd0;
                     hit = 1'b1;
                  end else if (cur_ff.value > alpha_ff && cur_ff.value < beta_ff) begin
                     beta_in = cur_ff.value;
                     slot_in = 2'd1;
                     hit = 1'b1;
                  end else if (cur_ff.value > alpha_ff && cur_ff.value > beta_ff &&
                               cur_ff.value < delta_ff) begin
                     delta_in = cur_ff.value;
                     slot_in = 2'd2;
                     hit = 1'b1;
                  end
                  if (hit) begin
                     res_chg_in = slot_in + 2'd1;
                     cnt_in = '0;
                     state_in = gwo_pkg::B_COPY;
                  end
               end
               gwo_pkg::K_UPD: begin
                  ar_addr = agent_addr(cur_ff.agent, 32'(cur_ff.dim));
                  lr_addr = leader_addr(2'd0, 32'(cur_ff.dim));
                  lrv_in = lvalid_ff[lr_addr];
                  acc_in = '0;
                  k_in = 2'd0;
                  ph_in = 3'd0;
                  state_in = gwo_pkg::B_UPD_L1;
               end
               gwo_pkg::K_ERR: begin
                  res_err_in = 1'b1;
               end
               default: begin
               end
            endcase
         end
         gwo_pkg::B_AGENT_DATA: begin
            res_pos_in = ar_data;
            state_in = gwo_pkg::B_RESULT;
         end
         gwo_pkg::B_LEAD_DATA: begin
            res_pos_in = lrv_ff ? lr_data : '0;
            if (cur_ff.agent[1:0] == 2'd0) begin
               res_score_in = alpha_ff;
            end else if (cur_ff.agent[1:0] == 2'd1) begin
               res_score_in = beta_ff;
            end else begin
               res_score_in = delta_ff;
            end
            state_in = gwo_pkg::B_RESULT;
         end
         gwo_pkg::B_COPY: begin
            // Read element cnt, write element cnt-1 into the leader
            if (9'(cnt_ff) < nd) begin
               ar_addr = agent_addr(cur_ff.agent, 32'(cnt_ff));
            end
            if (cnt_ff != '0) begin
               lw_en = 1'b1;
               lw_addr = leader_addr(slot_ff, 32'(cnt_ff - 1'b1));
               lw_data = ar_data;
               lvalid_in[lw_addr] = 1'b1;
            end
            if (9'(cnt_ff) == nd) begin
               state_in = gwo_pkg::B_RESULT;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         gwo_pkg::B_UPD_L1: begin
            x_in = ar_data;
            lead_in[0] = lrv_ff ? lr_data : '0;
            lr_addr = leader_addr(2'd1, 32'(cur_ff.dim));
            lrv_in = lvalid_ff[lr_addr];
            state_in = gwo_pkg::B_UPD_L2;
         end
         gwo_pkg::B_UPD_L2: begin
            lead_in[1] = lrv_ff ? lr_data : '0;
            lr_addr = leader_addr(2'd2, 32'(cur_ff.dim));
            lrv_in = lvalid_ff[lr_addr];
            state_in = gwo_pkg::B_UPD_L3;
         end
         gwo_pkg::B_UPD_L3: begin
            lead_in[2] = lrv_ff ? lr_data : '0;
            state_in = gwo_pkg::B_TERM;
         end
         gwo_pkg::B_TERM: begin
            // One leader term, five phases on a shared datapath
            case (ph_ff)
               3'd0: begin
                  pa_in = {34'(cur_ff.a_coeff) * 34'(r1), 1'b0};
                  ph_in = 3'd1;
               end
               3'd1: begin
                  diff_in = 51'($signed({1'b0, r2, 1'b0})) * 51'(ld) - (51'(x_ff) <<< 16);
                  pr = pa_ff + 35'd32768;
                  a16_in = $signed({2'b0, pr[34:16]}) - $signed({3'b0, cur_ff.a_coeff});
                  ph_in = 3'd2;
               end
               3'd2: begin
                  mag51 = diff_ff[50] ? 51'(-diff_ff) : 51'(diff_ff);
                  t52 = {1'b0, mag51} + 52'd32768;
                  d16_in = t52[51:16];
                  ph_in = 3'd3;
               end
               3'd3: begin
                  prod_in = 58'(a16_ff) * 58'($signed({1'b0, d16_ff}));
                  ph_in = 3'd4;
               end
               default: begin
                  acc_in = acc_ff + (gwo_pkg::ACC_W'(ld) <<< 16) - gwo_pkg::ACC_W'(prod_ff);
                  ph_in = 3'd0;
                  if (k_ff == 2'd2) begin
                     state_in = gwo_pkg::B_ROUND;
                  end else begin
                     k_in = k_ff + 2'd1;
                  end
               end
            endcase
         end
         gwo_pkg::B_ROUND: begin
            // Round half away from zero, drop the fraction bits
            neg_in = acc_ff[gwo_pkg::ACC_W-1];
            mag64 = acc_ff[gwo_pkg::ACC_W-1] ? gwo_pkg::ACC_W'(-acc_ff)
                                             : gwo_pkg::ACC_W'(acc_ff);
            mag64 = mag64 + gwo_pkg::ROUND_DIV;
            n_in = mag64[DW+15:16];
            q_in = '0;
            r_in = '0;
            step_in = '0;
            state_in = gwo_pkg::B_DIV;
         end
         gwo_pkg::B_DIV: begin
            // Divide by three, four quotient digits per cycle
            for (int j = 0; j < DD; j++) begin
               r3 = {rem, n_ff[DW-1-j]};
               if (r3 >= 3'd3) begin
                  rem = 2'(r3 - 3'd3);
                  qd[DD-1-j] = 1'b1;
               end else begin
                  rem = r3[1:0];
                  qd[DD-1-j] = 1'b0;
               end
            end
            r_in = rem;
            n_in = n_ff << DD;
            q_in = {q_ff[DW-DD-1:0], qd};
            step_in = step_ff + 4'd1;
            if (step_ff == 4'(gwo_pkg::DIV_STEPS - 1)) begin
               state_in = gwo_pkg::B_CLAMP;
            end
         end
         gwo_pkg::B_CLAMP: begin
            // Lower bound first, then upper; store the element
            qs = $signed({1'b0, q_ff});
            v = neg_ff ? -qs : qs;
            if (v < (DW+1)'(cfg.lower_bound)) begin
               v = (DW+1)'(cfg.lower_bound);
            end
            if (v > (DW+1)'(cfg.upper_bound)) begin
               v = (DW+1)'(cfg.upper_bound);
            end
            res_pos_in = v[31:0];
            aw_en = 1'b1;
            aw_addr = agent_addr(cur_ff.agent, 32'(cur_ff.dim));
            aw_data = v[31:0];
            state_in = gwo_pkg::B_RESULT;
         end
         gwo_pkg::B_RESULT: begin
            if (!out_full) begin
               out_push = 1'b1;
               state_in = gwo_pkg::B_IDLE;
            end
         end
         default: begin
            state_in = gwo_pkg::B_IDLE;
         end
      endcase
   end

   // Assemble the result item
   always_comb begin
      out_item.position = res_pos_ff;
      out_item.score = (cur_ff.kind == gwo_pkg::K_LREAD) ? res_score_ff : alpha_ff;
      out_item.changed = res_chg_ff;
      out_item.index_error = res_err_ff;
   end

   // Two-entry result queue
   assign rsp_empty = ocnt_ff == 2'd0;
   assign out_full = ocnt_ff == 2'd2;
   assign rsp = out_ff[ord_ff];

   always_comb begin
      out_in = out_ff;
      owr_in = owr_ff;
      ord_in = ord_ff;
      ocnt_in = ocnt_ff;
      if (out_push) begin
         out_in[owr_ff] = out_item;
         owr_in = ~owr_ff;
      end
      if (rsp_pop && !rsp_empty) begin
         ord_in = ~ord_ff;
      end
      if (out_push && !(rsp_pop && !rsp_empty)) begin
         ocnt_in = ocnt_ff + 2'd1;
      end else if (!out_push && rsp_pop && !rsp_empty) begin
         ocnt_in = ocnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= gwo_pkg::B_IDLE;
         alpha_ff <= gwo_pkg::SCORE_INF;
         beta_ff <= gwo_pkg::SCORE_INF;
         delta_ff <= gwo_pkg::SCORE_INF;
         lvalid_ff <= '0;
         owr_ff <= 1'b0;
         ord_ff <= 1'b0;
         ocnt_ff <= 2'd0;
      end else begin
         state_ff <= state_in;
         alpha_ff <= alpha_in;
         beta_ff <= beta_in;
         delta_ff <= delta_in;
         lvalid_ff <= lvalid_in;
         owr_ff <= owr_in;
         ord_ff <= ord_in;
         ocnt_ff <= ocnt_in;
      end
      cur_ff <= cur_in;
      x_ff <= x_in;
      lead_ff <= lead_in;
      k_ff <= k_in;
      slot_ff <= slot_in;
      ph_ff <= ph_in;
      pa_ff <= pa_in;
      a16_ff <= a16_in;
      diff_ff <= diff_in;
      d16_ff <= d16_in;
      prod_ff <= prod_in;
      acc_ff <= acc_in;
      neg_ff <= neg_in;
      n_ff <= n_in;
      q_ff <= q_in;
      r_ff <= r_in;
      step_ff <= step_in;
      cnt_ff <= cnt_in;
      res_pos_ff <= res_pos_in;
      res_score_ff <= res_score_in;
      res_chg_ff <= res_chg_in;
      res_err_ff <= res_err_in;
      lrv_ff <= lrv_in;
      out_ff <= out_in;
   end

endmodule

// ===== rtl/gwo_checker.sv =====
// Port-level checks of the grey wolf step engine, bound to the top level.
`include "grey_wolf_optimizer_step_top_macros.svh"

module gwo_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_full,
   input logic               rsp_empty,
   input logic               rsp_pop,
   input logic signed [31:0] rsp_position_out,
   input logic [1:0]         rsp_leader_changed,
   input logic               rsp_index_error
);

   // The result queue comes out of reset empty and the command queue not full
   `GWO_ASSERT_NXT(a_reset_empty, clock, reset, rsp_empty && !req_full)

   // An index error never carries data or a leader change
   `GWO_ASSERT_IMP(a_err_clean, clock, reset, !rsp_empty && rsp_index_error, rsp_leader_changed == 2'd0 && rsp_position_out == 32'sd0)

   // A waiting result stays until it is popped
   `GWO_ASSERT_NXT(a_rsp_hold, clock, !reset && !rsp_empty && !rsp_pop, !rsp_empty)

endmodule

bind grey_wolf_optimizer_step_top gwo_checker u_gwo_checker (
   .clock(clock), .reset(reset), .req_full(req_full), .rsp_empty(rsp_empty),
   .rsp_pop(rsp_pop), .rsp_position_out(rsp_position_out),
   .rsp_leader_changed(rsp_leader_changed), .rsp_index_error(rsp_index_error)
);
